>>> src/iq2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iq2_pkg;

	localparam int HALF_TAPS = 9;
	localparam int DEPTH     = 2 * HALF_TAPS;
	localparam int K_W       = $clog2(HALF_TAPS);
	localparam int PEND_W    = $clog2(HALF_TAPS + 1);
	localparam int CNT_W     = 5;
	localparam int SAMPLE_W  = 16;
	localparam int OUT_W     = 12;
	localparam int COEF_W    = 16;
	localparam int SUM_W     = SAMPLE_W + 1;
	localparam int PROD_W    = COEF_W + SUM_W;
	localparam int ACC_W     = PROD_W + 1;
	localparam int ACC_SHIFT = 19;
	localparam int COEF_IDX_W = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [OUT_W-1:0]    dac_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [COEF_W-1:0]   coef_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH0,
		S_LOAD,
		S_MAC,
		S_EVEN,
		S_ODD
	} state_t;

	typedef struct packed {
		logic           load;
		logic           step;
		logic [K_W-1:0] tap;
	} mac_ctrl_t;

	// center-outward half of the symmetric half-band kernel, scaled by 2^15
	function automatic coef_t coef(input logic [COEF_IDX_W-1:0] idx);
		coef_t c;
		case (idx)
			4'd0:    c = 16'sd20459;
			4'd1:    c = -16'sd5833;
			4'd2:    c = 16'sd2547;
			4'd3:    c = -16'sd1115;
			4'd4:    c = 16'sd439;
			4'd5:    c = -16'sd146;
			4'd6:    c = 16'sd38;
			4'd7:    c = -16'sd7;
			4'd8:    c = 16'sd1;
			default: c = 16'sd0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/iq_interpolate_by_two.sv
`timescale 1ns / 1ps
`default_nettype none

// 2x interpolator for bursts of 16-bit complex I/Q samples into 12-bit DAC codes.
// Each sample takes one transaction on the input; pairs come out HALF_TAPS
// samples later, even (sample >> 4) first, then the half-band midpoint. The
// input is not ready while a pair is computed and delivered. One dual-lane
// multiply-accumulate unit is stepped over the HALF_TAPS coefficient pairs for
// every pair; an item that emits nothing and is not the last of a burst leaves
// the input ready for the next sample. The last sample of a burst then flushes
// min(count, HALF_TAPS) pairs, marks the final midpoint with burst_end and
// returns the history to zero.
module iq_interpolate_by_two
	import iq2_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire sample_t in_i,
	input  wire sample_t in_q,
	input  wire logic    is_last,
	output logic         out_valid,
	input  wire logic    out_ready,
	output dac_t         out_i,
	output dac_t         out_q,
	output logic         is_odd,
	output logic         burst_end
);

	state_t              state_q, state_nxt;
	sample_t             hist_i_q [DEPTH];
	sample_t             hist_q_q [DEPTH];
	logic [CNT_W-1:0]    cnt_q;
	logic [PEND_W-1:0]   pend_q;
	logic                fin_q;
	logic [K_W-1:0]      tap_q;

	logic                in_fire, out_fire;
	logic                emit;
	logic [CNT_W:0]      before_p1;
	logic [PEND_W-1:0]   flush_n;
	logic                push_in, push_zero, clear_hist;
	mac_ctrl_t           mac_ctrl;
	dac_t                mid_i, mid_q;

	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign emit      = cnt_q >= CNT_W'(HALF_TAPS);
	assign before_p1 = {1'b0, cnt_q} + (CNT_W+1)'(1);
	assign flush_n   = (before_p1 > (CNT_W+1)'(HALF_TAPS)) ? PEND_W'(HALF_TAPS)
	                                                        : PEND_W'(before_p1);

	iq2_mac u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.hist_i (hist_i_q),
		.hist_q (hist_q_q),
		.mid_i  (mid_i),
		.mid_q  (mid_q)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (emit)
						state_nxt = S_LOAD;
					else if (is_last)
						state_nxt = S_PUSH0;
				end
			end
			S_PUSH0: state_nxt = S_LOAD;
			S_LOAD:  state_nxt = S_MAC;
			S_MAC: begin
				if (tap_q == K_W'(HALF_TAPS - 1))
					state_nxt = S_EVEN;
			end
			S_EVEN: begin
				if (out_ready)
					state_nxt = S_ODD;
			end
			S_ODD: begin
				if (out_ready)
					state_nxt = (pend_q != '0) ? S_PUSH0 : S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		is_odd        = 1'b0;
		burst_end     = 1'b0;
		out_i         = hist_i_q[HALF_TAPS-1][SAMPLE_W-1:SAMPLE_W-OUT_W];
		out_q         = hist_q_q[HALF_TAPS-1][SAMPLE_W-1:SAMPLE_W-OUT_W];
		push_in       = 1'b0;
		push_zero     = 1'b0;
		clear_hist    = 1'b0;
		mac_ctrl.load = 1'b0;
		mac_ctrl.step = 1'b0;
		mac_ctrl.tap  = tap_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				push_in  = in_valid;
			end
			S_PUSH0: push_zero = 1'b1;
			S_LOAD:  mac_ctrl.load = 1'b1;
			S_MAC:   mac_ctrl.step = 1'b1;
			S_EVEN:  out_valid = 1'b1;
			S_ODD: begin
				out_valid  = 1'b1;
				is_odd     = 1'b1;
				burst_end  = fin_q;
				out_i      = mid_i;
				out_q      = mid_q;
				clear_hist = out_ready && fin_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_q  <= '0;
			fin_q   <= 1'b0;
			tap_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_fire) begin
				cnt_q  <= (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + CNT_W'(1);
				pend_q <= is_last ? flush_n : '0;
				fin_q  <= 1'b0;
			end
			if (push_zero) begin
				pend_q <= pend_q - PEND_W'(1);
				fin_q  <= (pend_q == PEND_W'(1));
			end
			if (mac_ctrl.load)
				tap_q <= '0;
			else if (mac_ctrl.step)
				tap_q <= tap_q + K_W'(1);
			if (clear_hist) begin
				cnt_q <= '0;
				fin_q <= 1'b0;
			end
		end
	end

	// history line: entry DEPTH-1 is the newest sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < DEPTH; t++) begin
				hist_i_q[t] <= '0;
				hist_q_q[t] <= '0;
			end
		end else if (clear_hist) begin
			for (int t = 0; t < DEPTH; t++) begin
				hist_i_q[t] <= '0;
				hist_q_q[t] <= '0;
			end
		end else if (push_in || push_zero) begin
			for (int t = 0; t < DEPTH - 1; t++) begin
				hist_i_q[t] <= hist_i_q[t+1];
				hist_q_q[t] <= hist_q_q[t+1];
			end
			hist_i_q[DEPTH-1] <= push_in ? in_i : '0;
			hist_q_q[DEPTH-1] <= push_in ? in_q : '0;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && burst_end) |=> (cnt_q == '0 && pend_q == '0))
		else $error("burst state not cleared after final output");

	a_end_is_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && burst_end) |-> (is_odd && pend_q == '0))
		else $error("burst_end on an even output or with pairs pending");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(HALF_TAPS))
		else $error("flush count above HALF_TAPS");

endmodule

`default_nettype wire

>>> src/iq2_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module iq2_mac
	import iq2_pkg::*;
(
	input  wire logic      clk,
	input  wire mac_ctrl_t ctrl,
	input  wire sample_t   hist_i [DEPTH],
	input  wire sample_t   hist_q [DEPTH],
	output dac_t           mid_i,
	output dac_t           mid_q
);

	// lo lines walk outward from the center toward older samples, hi lines toward newer
	sample_t lo_i_q [HALF_TAPS];
	sample_t hi_i_q [HALF_TAPS];
	sample_t lo_q_q [HALF_TAPS];
	sample_t hi_q_q [HALF_TAPS];
	acc_t    acc_i_q;
	acc_t    acc_q_q;

	logic signed [SUM_W-1:0]  sum_i, sum_q;
	logic signed [PROD_W-1:0] prod_i, prod_q;
	coef_t                    c;

	always_comb begin
		c      = coef(COEF_IDX_W'(ctrl.tap));
		sum_i  = SUM_W'(lo_i_q[0]) + SUM_W'(hi_i_q[0]);
		sum_q  = SUM_W'(lo_q_q[0]) + SUM_W'(hi_q_q[0]);
		prod_i = PROD_W'(c) * PROD_W'(sum_i);
		prod_q = PROD_W'(c) * PROD_W'(sum_q);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			for (int j = 0; j < HALF_TAPS; j++) begin
				lo_i_q[j] <= hist_i[HALF_TAPS-1-j];
				hi_i_q[j] <= hist_i[HALF_TAPS+j];
				lo_q_q[j] <= hist_q[HALF_TAPS-1-j];
				hi_q_q[j] <= hist_q[HALF_TAPS+j];
			end
			acc_i_q <= '0;
			acc_q_q <= '0;
		end else if (ctrl.step) begin
			for (int j = 0; j < HALF_TAPS - 1; j++) begin
				lo_i_q[j] <= lo_i_q[j+1];
				hi_i_q[j] <= hi_i_q[j+1];
				lo_q_q[j] <= lo_q_q[j+1];
				hi_q_q[j] <= hi_q_q[j+1];
			end
			lo_i_q[HALF_TAPS-1] <= '0;
			hi_i_q[HALF_TAPS-1] <= '0;
			lo_q_q[HALF_TAPS-1] <= '0;
			hi_q_q[HALF_TAPS-1] <= '0;
			acc_i_q <= acc_i_q + ACC_W'(prod_i);
			acc_q_q <= acc_q_q + ACC_W'(prod_q);
		end
	end

	// arithmetic shift right then wrap: a plain bit slice
	assign mid_i = acc_i_q[ACC_SHIFT+OUT_W-1:ACC_SHIFT];
	assign mid_q = acc_q_q[ACC_SHIFT+OUT_W-1:ACC_SHIFT];

endmodule

`default_nettype wire
